[src/ial_pkg.sv]
// ial_pkg: shared types, constants and opcodes of the indexed array list
// used by the controller, the datapath, the top level and the checker
package ial_pkg;

  // list geometry
  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int OUT_CNT_W = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // compare width that holds both a position and a count plus one
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // operation codes
  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // request payload
  typedef struct packed {
    logic [1:0]               opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;
  } ial_req_t;

  // result payload
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] value_out;
    logic [OUT_CNT_W-1:0]     count;
    logic                     is_empty;
  } ial_rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture an accepted request
    logic commit;  // execute it and load the result register
  } ial_cmd_t;

endpackage

[src/ial_ctrl.sv]
// ial_ctrl: request sequencing state machine and result valid flag
// depends on ial_pkg
module ial_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ial_pkg::ial_cmd_t cmd_o
);
  import ial_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  // handshake and commands
  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.commit = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result valid: set on commit, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/ial_datapath.sv]
// ial_datapath: row of element cells, element count, range checks and result register
// depends on ial_pkg
module ial_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ial_pkg::ial_cmd_t cmd_i,
  input  ial_pkg::ial_req_t req_i,
  output ial_pkg::ial_rsp_t rsp_o
);
  import ial_pkg::*;

  ial_req_t                 req_q;
  ial_rsp_t                 rsp_q, rsp_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [DATA_W-1:0] cells_q [CAPACITY];

  logic [CMP_W-1:0]         pos_w, cnt_w;
  logic                     pos_nz, in_range, ins_ok;
  logic [IDX_W-1:0]         idx;
  logic signed [DATA_W-1:0] rd_val;
  logic                     do_ins, do_del;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  // range checks and read port
  assign pos_w    = CMP_W'(req_q.position);
  assign cnt_w    = CMP_W'(count_q);
  assign pos_nz   = (pos_w != '0);
  assign in_range = pos_nz && (pos_w <= cnt_w);
  assign ins_ok   = (count_q < CNT_W'(CAPACITY)) && pos_nz &&
                    (pos_w <= cnt_w + CMP_W'(1));
  assign idx      = IDX_W'(pos_w - CMP_W'(1));
  assign rd_val   = cells_q[idx];

  // operation decode
  always_comb begin
    rsp_d.ok        = 1'b0;
    rsp_d.value_out = '0;
    count_d         = count_q;
    do_ins          = 1'b0;
    do_del          = 1'b0;
    case (req_q.opcode)
      OP_GET: begin
        if (in_range) begin
          rsp_d.ok        = 1'b1;
          rsp_d.value_out = rd_val;
        end
      end
      OP_INSERT: begin
        if (ins_ok) begin
          rsp_d.ok = 1'b1;
          do_ins   = 1'b1;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          rsp_d.ok        = 1'b1;
          rsp_d.value_out = rd_val;
          do_del          = 1'b1;
          count_d         = count_q - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        rsp_d.ok = 1'b1;
        count_d  = '0;
      end
      default: begin
        rsp_d.ok = 1'b0;
      end
    endcase
    rsp_d.count    = OUT_CNT_W'(count_d);
    rsp_d.is_empty = (count_d == '0);
  end

  // element cells: each one loads the new value, its lower or its upper neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] lower, upper;
    logic                     take_lower, take_upper, take_new;

    if (i > 0) begin : g_lo
      assign lower = cells_q[i-1];
    end else begin : g_lo0
      assign lower = '0;
    end
    if (i < CAPACITY - 1) begin : g_up
      assign upper = cells_q[i+1];
    end else begin : g_up0
      assign upper = '0;
    end

    assign take_new   = do_ins && (IDX_W'(i) == idx);
    assign take_lower = do_ins && (i > 0) && (IDX_W'(i) > idx);
    assign take_upper = do_del && (i < CAPACITY - 1) && (IDX_W'(i) >= idx);

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (take_new) cells_q[i] <= req_q.value_in;
        else if (take_lower) cells_q[i] <= lower;
        else if (take_upper) cells_q[i] <= upper;
      end
    end
  end

  // element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

[src/indexed_array_list_top.sv]
// indexed_array_list_top: list of signed elements with get, insert, delete and clear
// depends on ial_pkg, ial_ctrl and ial_datapath
//
// usage
//   requests enter on in_valid_i / in_ready_o with an ial_req_t payload
//   (opcode, 1-based position, value to insert); each request yields one
//   result on out_valid_o / out_ready_i with an ial_rsp_t payload (ok,
//   value read or removed, element count after the request, empty flag)
//   an accepted request is held in the request register and executed from
//   it; its result enters the result register once no earlier result waits
//   there untaken; the controller takes no new request while it executes
//   one, and the row of cells shifts all elements at once on execution
//   a new request is accepted while the previous result waits in the
//   output register; if the receiver stalls, execution holds until the
//   waiting result is taken, and meanwhile in_ready_o stays low
//   reset clears the element count, so the list is empty; element cells
//   are not cleared and hold nothing until written

module indexed_array_list_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ial_pkg::ial_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ial_pkg::ial_rsp_t out_rsp_o
);
  import ial_pkg::*;

  ial_cmd_t cmd;

  // sequencing
  ial_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // element storage and result
  ial_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule

[src/ial_checker.sv]
// ial_checker: port-level assertions on the indexed array list top level
// depends on ial_pkg; bound to indexed_array_list_top
module ial_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ial_pkg::ial_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ial_pkg::ial_rsp_t out_rsp_o
);
  import ial_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed or dropped while stalled");

  // empty flag matches the count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.is_empty == (out_rsp_o.count == '0)))
    else $error("empty flag disagrees with count");

  // count never exceeds capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_rsp_o.count) <= 32'(CAPACITY)))
    else $error("count above capacity");

  // a refused request returns zero
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.ok |-> (out_rsp_o.value_out == '0))
    else $error("refused request returned a value");

  // clear always succeeds with an empty list, checked once it has passed the request and result registers
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.opcode == OP_CLEAR) && out_ready_i
    |=> ##1 out_valid_o && out_rsp_o.ok && out_rsp_o.is_empty)
    else $error("clear did not report an empty list");

endmodule

bind indexed_array_list_top ial_checker u_ial_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

[sim/tb_top.sv]
// tb_top: self-checking testbench of indexed_array_list_top (get, insert, delete, clear)
// depends on ial_pkg and the indexed_array_list_top rtl; keeps a shadow list to predict results
`timescale 1ns / 1ps

module tb_top;
  import ial_pkg::*;

  // run limits: about 1300 to 1420 requests, each delayed at worst by the longest sender
  // gap, the longest receiver stall and the block's own execution; several times that
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1280;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_MIXED, MIX_NOISE} mix_e;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  ial_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  ial_rsp_t rsp_data;

  // shadow copy of the list and the results it predicts
  logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
  int                       shadow_len = 0;
  ial_rsp_t                 expected_rsp_q [$];

  int  n_sent = 0;
  int  n_mismatch = 0;
  int  cycle_cnt = 0;
  bit  burst_mode = 1'b0;

  indexed_array_list_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req_data),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_rsp_o   (rsp_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_rsp_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // mostly zero, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // mix of full-range, small signed and extreme values
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    if (r < 75) return $signed($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  // apply one request to the shadow list and return the result it yields
  function automatic ial_rsp_t list_predict(ial_req_t req);
    ial_rsp_t rsp;
    int       pos;
    int       i;
    rsp = '0;
    pos = req.position;
    case (req.opcode)
      OP_GET: begin
        if (pos >= 1 && pos <= shadow_len) begin
          rsp.value_out = shadow_cells[pos-1];
          rsp.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (shadow_len < CAPACITY && pos >= 1 && pos <= shadow_len + 1) begin
          for (i = shadow_len; i >= pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[pos-1] = req.value_in;
          shadow_len++;
          rsp.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos >= 1 && pos <= shadow_len) begin
          rsp.value_out = shadow_cells[pos-1];
          for (i = pos - 1; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
          rsp.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_len = 0;
        rsp.ok = 1'b1;
      end
    endcase
    rsp.count    = OUT_CNT_W'(shadow_len);
    rsp.is_empty = (shadow_len == 0);
    return rsp;
  endfunction

  // drive one request from a falling edge, hold it until taken, then maybe idle
  task automatic send_req(input logic [1:0] op, input int pos,
                          input logic signed [DATA_W-1:0] val);
    int gap;
    req_data.opcode   = op;
    req_data.position = POS_W'(pos);
    req_data.value_in = val;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_rsp_q.push_back(list_predict(req_data));
    n_sent++;
    @(negedge clk);
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      req_data  = {2'($urandom), 6'($urandom), 32'($urandom)};
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_pause();
    req_valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
  endtask

  // one random request shaped by the traffic mix and the current length
  task automatic send_random(input mix_e mode);
    logic [1:0] op;
    int         hi;
    int         pos;
    int         r;
    r = $urandom_range(0, 99);
    case (mode)
      MIX_GROW:   op = (r < 70) ? OP_INSERT : (r < 90) ? OP_GET :
                       (r < 99) ? OP_DELETE : OP_CLEAR;
      MIX_SHRINK: op = (r < 65) ? OP_DELETE : (r < 88) ? OP_GET :
                       (r < 99) ? OP_INSERT : OP_CLEAR;
      MIX_MIXED:  op = (r < 35) ? OP_GET : (r < 65) ? OP_INSERT :
                       (r < 95) ? OP_DELETE : OP_CLEAR;
      default:    op = 2'($urandom_range(0, 3));
    endcase
    hi = (op == OP_INSERT) ? shadow_len + 1 : shadow_len;
    if (mode == MIX_NOISE) begin
      pos = $urandom_range(0, 63);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 85 && hi >= 1) begin
        pos = $urandom_range(1, hi);
      end else begin
        case ($urandom_range(0, 2))
          0:       pos = 0;
          1:       pos = hi + 1;
          default: pos = $urandom_range(0, 63);
        endcase
      end
    end
    send_req(op, pos, pick_value());
  endtask

  // refusals on an empty list and at position extremes, then a clear
  task automatic test_empty_list();
    send_req(OP_GET, 1, 32'sd5);
    send_req(OP_GET, 0, 32'sd0);
    send_req(OP_GET, 63, -1);
    send_req(OP_DELETE, 1, 32'sd0);
    send_req(OP_DELETE, 0, 32'sd0);
    send_req(OP_INSERT, 0, 32'sd11);
    send_req(OP_INSERT, 2, 32'sd12);
    send_req(OP_CLEAR, 0, 32'sd0);
  endtask

  // insert at front, middle, end and one past the end with extreme values, then read back
  task automatic test_insert_order();
    send_req(OP_INSERT, 1, 32'sh8000_0000);
    send_req(OP_INSERT, 2, 32'sh7fff_ffff);
    send_req(OP_INSERT, 1, -1);
    send_req(OP_INSERT, 2, 32'sd0);
    send_req(OP_INSERT, 6, 32'sd99);
    send_req(OP_INSERT, 5, 32'sh5a5a_5a5a);
    send_req(OP_GET, 5, 32'sd0);
    send_req(OP_GET, 6, 32'sd0);
    send_req(OP_GET, 3, 32'sd0);
  endtask

  // delete at front, end and middle, out of range, then clear and delete from the empty list
  task automatic test_delete_clear();
    send_req(OP_DELETE, 1, 32'sd0);
    send_req(OP_DELETE, 4, 32'sd0);
    send_req(OP_DELETE, 2, 32'sd0);
    send_req(OP_DELETE, 63, 32'sd0);
    send_req(OP_CLEAR, 63, 32'sh1234_5678);
    send_req(OP_DELETE, 1, 32'sd0);
  endtask

  // phases of growth, shrinkage, mixed and noise traffic with random content
  task automatic test_random_traffic();
    mix_e mode;
    int   phase_len;
    int   phase_no;
    int   target;
    phase_no = 0;
    target   = n_sent + RANDOM_ITEMS;
    while (n_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: mode = MIX_GROW;
        3, 4:    mode = MIX_SHRINK;
        5, 6, 7: mode = MIX_MIXED;
        default: mode = MIX_NOISE;
      endcase
      if (phase_no == 0) mode = MIX_GROW;
      phase_len  = (phase_no == 0) ? 120 : $urandom_range(40, 120);
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (phase_len) send_random(mode);
      burst_mode = 1'b0;
      if (phase_no % 4 == 1) drain_pause();
      phase_no++;
    end
  endtask

  // receiver stalls
  always begin
    @(negedge clk);
    if (!burst_mode && $urandom_range(0, 2) == 0) begin
      rsp_ready = 1'b0;
      repeat (pick_gap() + 1) @(negedge clk);
    end
    rsp_ready = 1'b1;
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin
    ial_rsp_t exp_rsp;
    if (rst_n && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("unexpected result at cycle %0d: ok=%0b value=%0d count=%0d empty=%0b",
                   cycle_cnt, rsp_data.ok, rsp_data.value_out, rsp_data.count,
                   rsp_data.is_empty);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (rsp_data.ok !== exp_rsp.ok || rsp_data.value_out !== exp_rsp.value_out ||
            rsp_data.count !== exp_rsp.count || rsp_data.is_empty !== exp_rsp.is_empty) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d", cycle_cnt);
            $display("  expected ok=%0b value=%0d count=%0d empty=%0b",
                     exp_rsp.ok, exp_rsp.value_out, exp_rsp.count, exp_rsp.is_empty);
            $display("  actual   ok=%0b value=%0d count=%0d empty=%0b",
                     rsp_data.ok, rsp_data.value_out, rsp_data.count, rsp_data.is_empty);
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_empty_list();
    test_insert_order();
    test_delete_clear();
    test_random_traffic();
    req_valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
